// File: rtl/icmp_echo_responder_defines.svh
// Assertion macros for the ICMP echo responder checker
`ifndef ICMP_ECHO_RESPONDER_DEFINES_SVH
`define ICMP_ECHO_RESPONDER_DEFINES_SVH

// Clocked assertion, off while reset is asserted
`define ICMP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Clocked assertion, checked during reset too
`define ICMP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/icmp_pkg.sv
// Types and constants shared by the ICMP echo responder modules
`timescale 1ns / 1ps
`default_nettype none

package icmp_pkg;

    localparam int HDR_LEN = 42;
    localparam int POS_W   = 6;

    typedef enum logic [1:0] {
        VERDICT_DROP = 2'd0,
        VERDICT_PASS = 2'd1,
        VERDICT_TX   = 2'd2
    } t_verdict;

    typedef enum logic [1:0] {
        OUT_BODY,
        OUT_MARKER,
        OUT_HDR
    } t_out_sel;

    localparam logic [POS_W-1:0] MAC_LEN       = 6'd6;
    localparam logic [POS_W-1:0] IP_ADDR_LEN   = 6'd4;
    localparam logic [POS_W-1:0] POS_SRC_MAC   = 6'd6;
    localparam logic [POS_W-1:0] POS_ETYPE_HI  = 6'd12;
    localparam logic [POS_W-1:0] POS_ETYPE_LO  = 6'd13;
    localparam logic [POS_W-1:0] POS_IP_FIRST  = 6'd14;
    localparam logic [POS_W-1:0] POS_ID_HI     = 6'd18;
    localparam logic [POS_W-1:0] POS_ID_LO     = 6'd19;
    localparam logic [POS_W-1:0] POS_TTL       = 6'd22;
    localparam logic [POS_W-1:0] POS_PROTO     = 6'd23;
    localparam logic [POS_W-1:0] POS_IPCS_HI   = 6'd24;
    localparam logic [POS_W-1:0] POS_IPCS_LO   = 6'd25;
    localparam logic [POS_W-1:0] POS_SRC_IP    = 6'd26;
    localparam logic [POS_W-1:0] POS_DST_IP    = 6'd30;
    localparam logic [POS_W-1:0] POS_IP_LAST   = 6'd33;
    localparam logic [POS_W-1:0] POS_ICMP_TYPE = 6'd34;
    localparam logic [POS_W-1:0] POS_ICMP_CODE = 6'd35;
    localparam logic [POS_W-1:0] POS_ICMPCS_HI = 6'd36;
    localparam logic [POS_W-1:0] POS_ICMPCS_LO = 6'd37;
    localparam logic [POS_W-1:0] POS_HDR_LAST  = 6'd41;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP     = 8'd1;
    localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
    localparam logic [7:0]  ICMP_ECHO_REP  = 8'd0;
    localparam logic [7:0]  REPLY_TTL      = 8'd64;
    localparam logic [15:0] REPLY_ID       = 16'd24851;

    typedef struct packed {
        logic             wr_en;
        logic [POS_W-1:0] wr_addr;
        logic             rd_en;
        logic [POS_W-1:0] rd_pos;
        logic             tx;
        logic             out_load;
        t_out_sel         out_sel;
        logic             out_last;
        t_verdict         out_verdict;
    } t_dp_cmd;

    typedef struct packed {
        logic is_ipv4;
        logic is_icmp;
        logic echo_req;
        logic echo_rep;
    } t_dp_stat;

endpackage

`default_nettype wire

// File: rtl/icmp_ifs.sv
// Stream and configuration channel interfaces of the ICMP echo responder
`timescale 1ns / 1ps
`default_nettype none

interface icmp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;
    modport source (output valid, frame_byte, last_byte, input ready);
    modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

interface icmp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] verdict;
    modport source (output valid, out_byte, out_last, verdict, input ready);
    modport sink (input valid, out_byte, out_last, verdict, output ready);
endinterface

interface icmp_cfg_if;
    logic valid;
    logic ready;
    logic drop_echo_requests;
    modport source (output valid, drop_echo_requests, input ready);
    modport sink (input valid, drop_echo_requests, output ready);
endinterface

`default_nettype wire

// File: rtl/icmp_dp.sv
// Datapath: header RAM, checksum arithmetic, reply rewrite and output word register
`timescale 1ns / 1ps
`default_nettype none

module icmp_dp (
    input  wire                        i_clk,
    input  wire  [7:0]                 i_byte,
    input  icmp_pkg::t_dp_cmd          i_cmd,
    output icmp_pkg::t_dp_stat         o_stat,
    output logic [7:0]                 o_out_byte,
    output logic                       o_out_last,
    output icmp_pkg::t_verdict         o_out_verdict
);

    localparam int SUM_W = 20;

    logic [7:0]       r_mem [icmp_pkg::HDR_LEN];
    logic [7:0]       r_rd_data;
    logic [7:0]       r_b12;
    logic [7:0]       r_b23;
    logic [7:0]       r_b34;
    logic [7:0]       r_b35;
    logic [7:0]       r_b36;
    logic [7:0]       r_b37;
    logic [SUM_W-1:0] r_ip_sum;
    logic [15:0]      r_ip_csum;
    logic [17:0]      r_icmp_sum;
    logic [15:0]      r_icmp_csum;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    icmp_pkg::t_verdict r_out_verdict;

    logic [icmp_pkg::POS_W-1:0] w_rd_addr;
    logic [7:0]       w_sub;
    logic [SUM_W-1:0] w_contrib;
    logic             w_in_ip;
    logic [16:0]      w_ip_f1;
    logic [15:0]      w_ip_f2;
    logic [17:0]      w_icmp_sum;
    logic [16:0]      w_icmp_f1;
    logic [15:0]      w_icmp_f2;
    logic [7:0]       w_hdr_byte;

    function automatic logic [icmp_pkg::POS_W-1:0] map_addr(
        input logic [icmp_pkg::POS_W-1:0] pos,
        input logic                       tx
    );
        logic [icmp_pkg::POS_W-1:0] a;
        a = pos;
        if (tx) begin
            if (pos < icmp_pkg::POS_SRC_MAC) begin
                a = pos + icmp_pkg::MAC_LEN;
            end else if (pos < icmp_pkg::POS_ETYPE_HI) begin
                a = pos - icmp_pkg::MAC_LEN;
            end else if (pos >= icmp_pkg::POS_SRC_IP && pos < icmp_pkg::POS_DST_IP) begin
                a = pos + icmp_pkg::IP_ADDR_LEN;
            end else if (pos >= icmp_pkg::POS_DST_IP && pos <= icmp_pkg::POS_IP_LAST) begin
                a = pos - icmp_pkg::IP_ADDR_LEN;
            end
        end
        return a;
    endfunction

    assign w_rd_addr = map_addr(i_cmd.rd_pos, i_cmd.tx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_cmd.wr_addr] <= i_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            case (i_cmd.wr_addr)
                icmp_pkg::POS_ETYPE_HI:  r_b12 <= i_byte;
                icmp_pkg::POS_PROTO:     r_b23 <= i_byte;
                icmp_pkg::POS_ICMP_TYPE: r_b34 <= i_byte;
                icmp_pkg::POS_ICMP_CODE: r_b35 <= i_byte;
                icmp_pkg::POS_ICMPCS_HI: r_b36 <= i_byte;
                icmp_pkg::POS_ICMPCS_LO: r_b37 <= i_byte;
                default: begin
                end
            endcase
        end
    end

    assign o_stat.is_ipv4  = ({r_b12, i_byte} == icmp_pkg::ETHERTYPE_IPV4);
    assign o_stat.is_icmp  = (r_b23 == icmp_pkg::PROTO_ICMP);
    assign o_stat.echo_req = (r_b34 == icmp_pkg::ICMP_ECHO_REQ);
    assign o_stat.echo_rep = (r_b34 == icmp_pkg::ICMP_ECHO_REP);

    // IP header sum with the reply fields already substituted
    always_comb begin
        case (i_cmd.wr_addr)
            icmp_pkg::POS_ID_HI:   w_sub = icmp_pkg::REPLY_ID[15:8];
            icmp_pkg::POS_ID_LO:   w_sub = icmp_pkg::REPLY_ID[7:0];
            icmp_pkg::POS_TTL:     w_sub = icmp_pkg::REPLY_TTL;
            icmp_pkg::POS_IPCS_HI: w_sub = 8'h00;
            icmp_pkg::POS_IPCS_LO: w_sub = 8'h00;
            default:               w_sub = i_byte;
        endcase
    end

    assign w_contrib = i_cmd.wr_addr[0] ? {{(SUM_W-8){1'b0}}, w_sub}
                                        : {{(SUM_W-16){1'b0}}, w_sub, 8'h00};
    assign w_in_ip   = (i_cmd.wr_addr >= icmp_pkg::POS_IP_FIRST) &&
                       (i_cmd.wr_addr <= icmp_pkg::POS_IP_LAST);

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            if (i_cmd.wr_addr == '0) begin
                r_ip_sum <= '0;
            end else if (w_in_ip) begin
                r_ip_sum <= r_ip_sum + w_contrib;
            end
        end
    end

    assign w_ip_f1 = {1'b0, r_ip_sum[15:0]} + {13'd0, r_ip_sum[SUM_W-1:16]};
    assign w_ip_f2 = w_ip_f1[15:0] + {15'd0, w_ip_f1[16]};

    // ICMP checksum update for the type change
    assign w_icmp_sum = {2'b00, ~{r_b36, r_b37}} + {2'b00, ~{r_b34, r_b35}} +
                        {10'd0, r_b35};
    assign w_icmp_f1  = {1'b0, r_icmp_sum[15:0]} + {15'd0, r_icmp_sum[17:16]};
    assign w_icmp_f2  = w_icmp_f1[15:0] + {15'd0, w_icmp_f1[16]};

    always_ff @(posedge i_clk) begin
        r_ip_csum   <= ~w_ip_f2;
        r_icmp_sum  <= w_icmp_sum;
        r_icmp_csum <= ~w_icmp_f2;
    end

    always_comb begin
        w_hdr_byte = r_rd_data;
        if (i_cmd.tx) begin
            case (i_cmd.rd_pos)
                icmp_pkg::POS_ID_HI:     w_hdr_byte = icmp_pkg::REPLY_ID[15:8];
                icmp_pkg::POS_ID_LO:     w_hdr_byte = icmp_pkg::REPLY_ID[7:0];
                icmp_pkg::POS_TTL:       w_hdr_byte = icmp_pkg::REPLY_TTL;
                icmp_pkg::POS_IPCS_HI:   w_hdr_byte = r_ip_csum[15:8];
                icmp_pkg::POS_IPCS_LO:   w_hdr_byte = r_ip_csum[7:0];
                icmp_pkg::POS_ICMP_TYPE: w_hdr_byte = icmp_pkg::ICMP_ECHO_REP;
                icmp_pkg::POS_ICMPCS_HI: w_hdr_byte = r_icmp_csum[15:8];
                icmp_pkg::POS_ICMPCS_LO: w_hdr_byte = r_icmp_csum[7:0];
                default:                 w_hdr_byte = r_rd_data;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                icmp_pkg::OUT_BODY:   r_out_byte <= i_byte;
                icmp_pkg::OUT_MARKER: r_out_byte <= 8'h00;
                icmp_pkg::OUT_HDR:    r_out_byte <= w_hdr_byte;
                default:              r_out_byte <= 8'h00;
            endcase
            r_out_last    <= i_cmd.out_last;
            r_out_verdict <= i_cmd.out_verdict;
        end
    end

    assign o_out_byte    = r_out_byte;
    assign o_out_last    = r_out_last;
    assign o_out_verdict = r_out_verdict;

endmodule

`default_nettype wire

// File: rtl/icmp_ctrl.sv
// Controller: frame sequencing, verdict, header release and output word valid
`timescale 1ns / 1ps
`default_nettype none

module icmp_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_last,
    output logic                o_in_ready,
    input  wire                 i_out_ready,
    output logic                o_out_valid,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_drop,
    output logic                o_cfg_ready,
    input  icmp_pkg::t_dp_stat  i_stat,
    output icmp_pkg::t_dp_cmd   o_cmd
);

    typedef enum logic [1:0] {
        ST_RECV,
        ST_READ,
        ST_LOAD
    } t_state;

    t_state                     r_state, n_state;
    logic [icmp_pkg::POS_W-1:0] r_count, n_count;
    logic                       r_body, n_body;
    icmp_pkg::t_verdict         r_verdict, n_verdict;
    logic [icmp_pkg::POS_W-1:0] r_pos, n_pos;
    logic [icmp_pkg::POS_W-1:0] r_end_idx, n_end_idx;
    logic                       r_end_last, n_end_last;
    logic                       r_out_valid, n_out_valid;
    logic                       r_drop_req;

    logic                       w_in_fire;
    logic                       w_has_v;
    icmp_pkg::t_verdict         w_v;

    assign o_in_ready  = (r_state == ST_RECV) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_cfg_ready = 1'b1;
    assign w_in_fire   = i_in_valid && o_in_ready;

    always_comb begin
        w_has_v = 1'b0;
        w_v     = icmp_pkg::VERDICT_DROP;
        if (r_count == icmp_pkg::POS_ETYPE_LO) begin
            if (!i_stat.is_ipv4) begin
                w_has_v = 1'b1;
                w_v     = icmp_pkg::VERDICT_PASS;
            end
        end else if (r_count == icmp_pkg::POS_IP_LAST) begin
            if (!i_stat.is_icmp) begin
                w_has_v = 1'b1;
                w_v     = icmp_pkg::VERDICT_PASS;
            end
        end else if (r_count == icmp_pkg::POS_HDR_LAST) begin
            w_has_v = 1'b1;
            if (i_stat.echo_req) begin
                w_v = r_drop_req ? icmp_pkg::VERDICT_DROP : icmp_pkg::VERDICT_TX;
            end else if (i_stat.echo_rep) begin
                w_v = icmp_pkg::VERDICT_PASS;
            end else begin
                w_v = icmp_pkg::VERDICT_DROP;
            end
        end
        if (!w_has_v && i_in_last) begin
            w_has_v = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_body      = r_body;
        n_verdict   = r_verdict;
        n_pos       = r_pos;
        n_end_idx   = r_end_idx;
        n_end_last  = r_end_last;
        n_out_valid = r_out_valid && !i_out_ready;

        o_cmd             = '0;
        o_cmd.wr_addr     = r_count;
        o_cmd.rd_pos      = r_pos;
        o_cmd.tx          = (r_verdict == icmp_pkg::VERDICT_TX);
        o_cmd.out_sel     = icmp_pkg::OUT_BODY;
        o_cmd.out_verdict = r_verdict;

        case (r_state)
            ST_RECV: begin
                if (w_in_fire) begin
                    if (r_body) begin
                        if (r_verdict != icmp_pkg::VERDICT_DROP) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.out_last = i_in_last;
                            n_out_valid    = 1'b1;
                        end
                        if (i_in_last) begin
                            n_body    = 1'b0;
                            n_verdict = icmp_pkg::VERDICT_DROP;
                        end
                    end else begin
                        o_cmd.wr_en = 1'b1;
                        if (!w_has_v) begin
                            n_count = r_count + 6'd1;
                        end else if (w_v == icmp_pkg::VERDICT_DROP) begin
                            // drop marker word, swallow the rest of the frame
                            o_cmd.out_load    = 1'b1;
                            o_cmd.out_sel     = icmp_pkg::OUT_MARKER;
                            o_cmd.out_last    = 1'b1;
                            o_cmd.out_verdict = icmp_pkg::VERDICT_DROP;
                            n_out_valid       = 1'b1;
                            n_count           = '0;
                            n_body            = !i_in_last;
                            n_verdict         = icmp_pkg::VERDICT_DROP;
                        end else begin
                            n_count    = '0;
                            n_verdict  = w_v;
                            n_end_idx  = r_count;
                            n_end_last = i_in_last;
                            n_pos      = '0;
                            n_state    = ST_READ;
                        end
                    end
                end
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = ST_LOAD;
            end
            ST_LOAD: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = icmp_pkg::OUT_HDR;
                    o_cmd.out_last = (r_pos == r_end_idx) && r_end_last;
                    n_out_valid    = 1'b1;
                    if (r_pos == r_end_idx) begin
                        n_state = ST_RECV;
                        n_body  = !r_end_last;
                        if (r_end_last) begin
                            n_verdict = icmp_pkg::VERDICT_DROP;
                        end
                    end else begin
                        n_pos   = r_pos + 6'd1;
                        n_state = ST_READ;
                    end
                end
            end
            default: begin
                n_state = ST_RECV;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RECV;
            r_count     <= '0;
            r_body      <= 1'b0;
            r_verdict   <= icmp_pkg::VERDICT_DROP;
            r_pos       <= '0;
            r_end_idx   <= '0;
            r_end_last  <= 1'b0;
            r_out_valid <= 1'b0;
            r_drop_req  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_body      <= n_body;
            r_verdict   <= n_verdict;
            r_pos       <= n_pos;
            r_end_idx   <= n_end_idx;
            r_end_last  <= n_end_last;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_drop_req <= i_cfg_drop;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/icmp_echo_responder.sv
// ICMP echo responder: byte stream in, dropped, passed or echo-reply byte stream out.
// Header bytes go into the header RAM; no word out until the verdict byte (13, 33 or 41) or the last byte.
// Release of held header: each word is read from the header RAM read port (ST_READ) and then
// loaded (ST_LOAD), up to 42 words; no new input byte is accepted while an output word is pending.
// Body words are registered: output valid rises in the cycle after the input byte is accepted.
// Reset (sync, active low) clears control state and the drop flag; header RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module icmp_echo_responder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    icmp_in_if.sink     i_frame,
    icmp_out_if.source  o_reply,
    icmp_cfg_if.sink    i_cfg
);

    icmp_pkg::t_dp_cmd  w_cmd;
    icmp_pkg::t_dp_stat w_stat;
    icmp_pkg::t_verdict w_out_verdict;

    icmp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_frame.valid),
        .i_in_last   (i_frame.last_byte),
        .o_in_ready  (i_frame.ready),
        .i_out_ready (o_reply.ready),
        .o_out_valid (o_reply.valid),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_drop  (i_cfg.drop_echo_requests),
        .o_cfg_ready (i_cfg.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    icmp_dp u_dp (
        .i_clk         (i_clk),
        .i_byte        (i_frame.frame_byte),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .o_out_byte    (o_reply.out_byte),
        .o_out_last    (o_reply.out_last),
        .o_out_verdict (w_out_verdict)
    );

    assign o_reply.verdict = w_out_verdict;

endmodule

`default_nettype wire

// File: rtl/icmp_chk.sv
// Port-level checker for the ICMP echo responder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "icmp_echo_responder_defines.svh"

module icmp_chk (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_valid,
    input wire       i_out_ready,
    input wire [7:0] i_out_byte,
    input wire       i_out_last,
    input wire [1:0] i_verdict
);

    logic       r_mid;
    logic [1:0] r_frame_verdict;
    logic       w_out_fire;

    assign w_out_fire = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mid           <= 1'b0;
            r_frame_verdict <= '0;
        end else if (w_out_fire) begin
            r_mid           <= !i_out_last;
            r_frame_verdict <= i_verdict;
        end
    end

    `ICMP_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) && $stable(i_out_last) && $stable(i_verdict), "output word changed while stalled")
    `ICMP_ASSERT_ALWAYS(a_reset_idle, !i_rst_n |=> !i_out_valid, "output valid after reset")
    `ICMP_ASSERT(a_drop_marker, i_out_valid && i_verdict == icmp_pkg::VERDICT_DROP |-> i_out_byte == 8'h00 && i_out_last, "malformed drop marker")
    `ICMP_ASSERT(a_frame_verdict, i_out_valid && r_mid |-> i_verdict == r_frame_verdict, "verdict changed within a frame")

endmodule

bind icmp_echo_responder icmp_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_reply.valid),
    .i_out_ready (o_reply.ready),
    .i_out_byte  (o_reply.out_byte),
    .i_out_last  (o_reply.out_last),
    .i_verdict   (o_reply.verdict)
);

`default_nettype wire
